// ===== sv/huffman_prefix_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// huffman_prefix_decoder assertion macros
// concurrent assertion shorthands for the checker file
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_PREFIX_DECODER_ASSERT_SVH
`define HUFFMAN_PREFIX_DECODER_ASSERT_SVH

// generic clocked property with async active-low reset disable
`define HPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// signal holds while a transaction is stalled
`define HPD_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// ===== sv/hpd_pkg.sv =====
// ---------------------------------------------------------------------------
// hpd_pkg
// shared types and constants of the huffman prefix decoder
// ---------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

  // fixed field widths
  localparam int IDX_BITS  = 8;
  localparam int CODE_BITS = 16;
  localparam int LEN_BITS  = 5;
  localparam int SYM_BITS  = 8;

  // longest code a table entry can hold
  localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(CODE_BITS);

  // item commands
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_BIT  = 1'b1
  } cmd_e;

  // one code table entry
  typedef struct packed {
    logic [LEN_BITS-1:0]  len;
    logic [CODE_BITS-1:0] code;
    logic [SYM_BITS-1:0]  sym;
  } entry_t;

  // registered table read data
  typedef struct packed {
    logic   vld;
    entry_t ent;
  } tbl_rd_t;

  // one result transaction
  typedef struct packed {
    logic                symbol_valid;
    logic [SYM_BITS-1:0] symbol;
    logic                overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/huffman_prefix_decoder.sv =====
// ---------------------------------------------------------------------------
// huffman_prefix_decoder
// table-driven prefix code decoder with a scanned code table memory
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | command, entry_*, code_bit
//   out     | output    | out_valid_o/out_ready_i| symbol_valid, symbol, overflow
//
// a load transaction passes through the load and done states before the next ready
// a bit transaction scans the table until entry k, the first match, has been
// compared, or through every entry when none matches, with one table
// memory read per entry
// reset clears the per-entry valid bits at once, no clearing pass
// a full output register holds the sequencer in its done state until taken
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_prefix_decoder
  import hpd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic [IDX_BITS-1:0]  entry_index_i,
  input  wire logic [CODE_BITS-1:0] entry_code_i,
  input  wire logic [LEN_BITS-1:0]  entry_length_i,
  input  wire logic [SYM_BITS-1:0]  entry_symbol_i,
  input  wire logic                 code_bit_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      symbol_valid_o,
  output logic [SYM_BITS-1:0]       symbol_o,
  output logic                      overflow_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic          tbl_wr_en;
  logic [AW-1:0] tbl_wr_addr;
  entry_t        tbl_wr_data;
  logic          tbl_rd_en;
  logic [AW-1:0] tbl_rd_addr;
  tbl_rd_t       tbl_rd;
  logic          res_vld;
  res_t          res;
  logic          out_free;
  logic          out_vld_q;
  res_t          out_q;

  hpd_table #(
    .ENTRIES (TABLE_ENTRIES),
    .AW      (AW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (tbl_rd_addr),
    .rd_o      (tbl_rd)
  );

  hpd_ctrl #(
    .ENTRIES (TABLE_ENTRIES),
    .MAX_LEN (MAX_CODE_LEN),
    .AW      (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .entry_code_i   (entry_code_i),
    .entry_length_i (entry_length_i),
    .entry_symbol_i (entry_symbol_i),
    .code_bit_i     (code_bit_i),
    .tbl_wr_en_o    (tbl_wr_en),
    .tbl_wr_addr_o  (tbl_wr_addr),
    .tbl_wr_data_o  (tbl_wr_data),
    .tbl_rd_en_o    (tbl_rd_en),
    .tbl_rd_addr_o  (tbl_rd_addr),
    .tbl_rd_i       (tbl_rd),
    .res_vld_o      (res_vld),
    .res_o          (res),
    .out_free_i     (out_free)
  );

  // output register, free when empty or being taken
  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_vld && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign symbol_valid_o = out_q.symbol_valid;
  assign symbol_o       = out_q.symbol;
  assign overflow_o     = out_q.overflow;

endmodule

`default_nettype wire

// ===== sv/hpd_table.sv =====
// ---------------------------------------------------------------------------
// hpd_table
// code table memory, one write and one registered read port, valid bits
// ---------------------------------------------------------------------------
`default_nettype none

module hpd_table
  import hpd_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire entry_t        wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output tbl_rd_t            rd_o
);

  entry_t           mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  tbl_rd_t          rd_q;

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.vld <= vld_q[rd_addr_i];
      rd_q.ent <= mem_q[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ===== sv/hpd_ctrl.sv =====
// ---------------------------------------------------------------------------
// hpd_ctrl
// item sequencer: table writes, pending code and table scan per bit
// ---------------------------------------------------------------------------
`default_nettype none

module hpd_ctrl
  import hpd_pkg::*;
#(
  parameter int ENTRIES = 256,
  parameter int MAX_LEN = 16,
  parameter int AW      = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic [IDX_BITS-1:0]  entry_index_i,
  input  wire logic [CODE_BITS-1:0] entry_code_i,
  input  wire logic [LEN_BITS-1:0]  entry_length_i,
  input  wire logic [SYM_BITS-1:0]  entry_symbol_i,
  input  wire logic                 code_bit_i,
  // table port
  output logic                      tbl_wr_en_o,
  output logic [AW-1:0]             tbl_wr_addr_o,
  output entry_t                    tbl_wr_data_o,
  output logic                      tbl_rd_en_o,
  output logic [AW-1:0]             tbl_rd_addr_o,
  input  wire tbl_rd_t              tbl_rd_i,
  // result toward output register
  output logic                      res_vld_o,
  output res_t                      res_o,
  input  wire logic                 out_free_i
);

  localparam int PW = MAX_LEN;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;
  entry_t              ent_q, ent_d;
  logic [PW-1:0]       pend_bits_q, pend_bits_d;
  logic [LW-1:0]       pend_len_q, pend_len_d;
  logic [PW-1:0]       cand_bits_q, cand_bits_d;
  logic [LW-1:0]       cand_len_q, cand_len_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                issued_all_q, issued_all_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                cmp_last_q, cmp_last_d;
  res_t                res_q, res_d;

  logic in_range;
  logic hit;

  // load slot inside the table
  assign in_range = {1'b0, idx_q} < (IDX_BITS + 1)'(ENTRIES);

  // compare of the entry read last cycle against the candidate code
  assign hit = cmp_vld_q && tbl_rd_i.vld
               && (tbl_rd_i.ent.len != '0) && (tbl_rd_i.ent.len <= LEN_LIMIT)
               && (32'(tbl_rd_i.ent.len) == 32'(cand_len_q))
               && (32'(tbl_rd_i.ent.code) == 32'(cand_bits_q));

  assign tbl_wr_addr_o = idx_q[AW-1:0];
  assign tbl_wr_data_o = ent_q;
  assign tbl_rd_addr_o = addr_q;
  assign res_o         = res_q;

  // next state
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    ent_d        = ent_q;
    pend_bits_d  = pend_bits_q;
    pend_len_d   = pend_len_q;
    cand_bits_d  = cand_bits_q;
    cand_len_d   = cand_len_q;
    addr_d       = addr_q;
    issued_all_d = issued_all_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_last_d   = cmp_last_q;
    res_d        = res_q;
    in_ready_o   = (state_q == ST_IDLE);
    res_vld_o    = (state_q == ST_DONE);
    tbl_wr_en_o  = 1'b0;
    tbl_rd_en_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d       = entry_index_i;
          ent_d.len   = entry_length_i;
          ent_d.code  = entry_code_i;
          ent_d.sym   = entry_symbol_i;
          cand_bits_d = {pend_bits_q[PW-2:0], code_bit_i};
          cand_len_d  = pend_len_q + LW'(1);
          if (command_i == CMD_LOAD) begin
            state_d = ST_LOAD;
          end else begin
            state_d      = ST_SCAN;
            addr_d       = '0;
            issued_all_d = 1'b0;
            cmp_vld_d    = 1'b0;
            cmp_last_d   = 1'b0;
          end
        end
      end
      ST_LOAD: begin
        tbl_wr_en_o = in_range;
        res_d       = '0;
        state_d     = ST_DONE;
      end
      ST_SCAN: begin
        cmp_vld_d = 1'b0;
        if (hit) begin
          // first matching entry decides
          res_d.symbol_valid = 1'b1;
          res_d.symbol       = tbl_rd_i.ent.sym;
          res_d.overflow     = 1'b0;
          pend_bits_d        = '0;
          pend_len_d         = '0;
          state_d            = ST_DONE;
        end else if (cmp_vld_q && cmp_last_q) begin
          // no entry matched
          res_d = '0;
          if (32'(cand_len_q) >= 32'(MAX_LEN)) begin
            res_d.overflow = 1'b1;
            pend_bits_d    = '0;
            pend_len_d     = '0;
          end else begin
            pend_bits_d = cand_bits_q;
            pend_len_d  = cand_len_q;
          end
          state_d = ST_DONE;
        end else if (!issued_all_q) begin
          // issue next table read
          tbl_rd_en_o = 1'b1;
          cmp_vld_d   = 1'b1;
          cmp_last_d  = (addr_q == LAST_ADDR);
          if (addr_q == LAST_ADDR) begin
            issued_all_d = 1'b1;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      ent_q        <= '0;
      pend_bits_q  <= '0;
      pend_len_q   <= '0;
      cand_bits_q  <= '0;
      cand_len_q   <= '0;
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      ent_q        <= ent_d;
      pend_bits_q  <= pend_bits_d;
      pend_len_q   <= pend_len_d;
      cand_bits_q  <= cand_bits_d;
      cand_len_q   <= cand_len_d;
      addr_q       <= addr_d;
      issued_all_q <= issued_all_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_last_q   <= cmp_last_d;
      res_q        <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpd_checker.sv =====
// ---------------------------------------------------------------------------
// hpd_checker
// port-level assertions on the huffman prefix decoder, bound to the top
// ---------------------------------------------------------------------------
`default_nettype none

`include "huffman_prefix_decoder_assert.svh"

module hpd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        command_i,
  input wire logic [7:0]  entry_index_i,
  input wire logic [15:0] entry_code_i,
  input wire logic [4:0]  entry_length_i,
  input wire logic [7:0]  entry_symbol_i,
  input wire logic        code_bit_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        symbol_valid_o,
  input wire logic [7:0]  symbol_o,
  input wire logic        overflow_o
);

  // stalled result transaction stays presented
  `HPD_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out valid dropped")
  `HPD_ASSERT_HOLD(a_out_symbol_hold, clk_i, rst_ni, out_valid_o, out_ready_i, symbol_o, "symbol changed")

  // a result is either a symbol, an overflow or neither
  `HPD_ASSERT(a_flags_excl, clk_i, rst_ni, out_valid_o |-> !(symbol_valid_o && overflow_o), "both flags")

  // no symbol means a zero symbol byte
  `HPD_ASSERT(a_symbol_zero, clk_i, rst_ni, out_valid_o && !symbol_valid_o |-> symbol_o == 8'd0, "stray symbol")

  // one item at a time: the sequencer is busy right after an acceptance
  `HPD_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "early ready")

endmodule

bind huffman_prefix_decoder hpd_checker u_checker (.*);

`default_nettype wire

// ===== tb/huffman_prefix_decoder_test.sv =====
// ---------------------------------------------------------------------------
// huffman_prefix_decoder_test
// self-checking bench for the table-driven prefix code decoder: a directed
// pass over the table corner cases, then random phases that load a fresh
// prefix code and stream its code words, mixed with stray bits and loads,
// under random idling on both channels and one long output hold-off
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_prefix_decoder_test
  import hpd_pkg::*;
();

  localparam int NUM_SLOTS    = 256;
  localparam int MAX_LEN      = 16;
  localparam int ITEM_TARGET  = 1550;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;

  // reference decoder state and the queue of expected symbol results
  class symbol_scoreboard;
    entry_t               slots [NUM_SLOTS];
    logic [CODE_BITS-1:0] pend_bits;
    int                   pend_len;
    res_t                 expected_symbols [$];
    int                   errors;
    int                   n_loads;
    int                   n_bits;
    int                   n_decoded;
    int                   n_overflow;

    function new();
      foreach (slots[i]) slots[i] = '0;
      pend_bits  = '0;
      pend_len   = 0;
      errors     = 0;
      n_loads    = 0;
      n_bits     = 0;
      n_decoded  = 0;
      n_overflow = 0;
    endfunction

    // predict the result of one accepted input transaction
    function void apply_item(cmd_e cmd, logic [IDX_BITS-1:0] idx,
                             logic [CODE_BITS-1:0] code, logic [LEN_BITS-1:0] len,
                             logic [SYM_BITS-1:0] sym, logic bit_in);
      res_t r;
      int   hit;
      r   = '0;
      hit = -1;
      if (cmd == CMD_LOAD) begin
        if (int'(idx) < NUM_SLOTS) slots[idx] = {len, code, sym};
        n_loads++;
      end else begin
        n_bits++;
        pend_bits = {pend_bits[CODE_BITS-2:0], bit_in};
        pend_len++;
        // lowest matching slot wins; lengths above the code field never match
        for (int i = 0; i < NUM_SLOTS && hit < 0; i++) begin
          if (slots[i].len != '0 && slots[i].len <= CODE_BITS &&
              int'(slots[i].len) == pend_len && slots[i].code == pend_bits)
            hit = i;
        end
        if (hit >= 0) begin
          r.symbol_valid = 1'b1;
          r.symbol       = slots[hit].sym;
          pend_bits      = '0;
          pend_len       = 0;
        end else if (pend_len >= MAX_LEN) begin
          r.overflow = 1'b1;
          pend_bits  = '0;
          pend_len   = 0;
        end
      end
      expected_symbols.insert(expected_symbols.size(), r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_symbol(res_t got);
      res_t want;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: symbol_valid %0b symbol %02h overflow %0b",
                 $time, got.symbol_valid, got.symbol, got.overflow);
        return;
      end
      want = expected_symbols.pop_front();
      if (want.symbol_valid) n_decoded++;
      if (want.overflow) n_overflow++;
      if (got.symbol_valid !== want.symbol_valid) begin
        errors++;
        $display("%0t: symbol_valid mismatch: expected %0b actual %0b",
                 $time, want.symbol_valid, got.symbol_valid);
      end
      if (got.symbol !== want.symbol) begin
        errors++;
        $display("%0t: symbol mismatch: expected %02h actual %02h",
                 $time, want.symbol, got.symbol);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow mismatch: expected %0b actual %0b",
                 $time, want.overflow, got.overflow);
      end
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction
  endclass

  // clock, reset and block ports
  logic                 clk_i        = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready_o;
  cmd_e                 command      = CMD_LOAD;
  logic [IDX_BITS-1:0]  entry_index  = '0;
  logic [CODE_BITS-1:0] entry_code   = '0;
  logic [LEN_BITS-1:0]  entry_length = '0;
  logic [SYM_BITS-1:0]  entry_symbol = '0;
  logic                 code_bit     = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready    = 1'b0;
  logic                 symbol_valid_o;
  logic [SYM_BITS-1:0]  symbol_o;
  logic                 overflow_o;

  // stimulus control shared between processes
  symbol_scoreboard sb;
  int               n_sent   = 0;
  int               send_pct = 0;
  int               recv_pct = 0;
  bit               quiet    = 1'b0;
  bit               hold_req = 1'b0;
  int               n_holds  = 0;
  int               cycles   = 0;

  // current prefix code: leaf codes and lengths, and slots to clear later
  int word_code [$];
  int word_len  [$];
  int live_slots [$];

  huffman_prefix_decoder #(
    .TABLE_ENTRIES(NUM_SLOTS),
    .MAX_CODE_LEN (MAX_LEN)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .command_i      (command),
    .entry_index_i  (entry_index),
    .entry_code_i   (entry_code),
    .entry_length_i (entry_length),
    .entry_symbol_i (entry_symbol),
    .code_bit_i     (code_bit),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .symbol_valid_o (symbol_valid_o),
    .symbol_o       (symbol_o),
    .overflow_o     (overflow_o)
  );

  // clock generation
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o)
        sb.apply_item(command, entry_index, entry_code, entry_length, entry_symbol, code_bit);
      if (out_valid_o && out_ready)
        sb.check_symbol({symbol_valid_o, symbol_o, overflow_o});
    end
  end

  // result receiver with random stall bursts and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        n_holds++;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < recv_pct) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one transaction, after an optional idle burst, until accepted
  task automatic send_item(input cmd_e cmd, input logic [IDX_BITS-1:0] idx,
                           input logic [CODE_BITS-1:0] code,
                           input logic [LEN_BITS-1:0] len,
                           input logic [SYM_BITS-1:0] sym, input logic bit_in);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < send_pct) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    entry_index  <= idx;
    entry_code   <= code;
    entry_length <= len;
    entry_symbol <= sym;
    code_bit     <= bit_in;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // table write; the code bit rides along at random
  task automatic send_load(input int idx, input int code, input int len, input int sym);
    live_slots.insert(live_slots.size(), idx);
    send_item(CMD_LOAD, IDX_BITS'(idx), CODE_BITS'(code), LEN_BITS'(len),
              SYM_BITS'(sym), 1'($urandom_range(0, 1)));
  endtask

  // compressed bit; table fields carry random junk
  task automatic send_bit(input logic bit_in);
    send_item(CMD_BIT, IDX_BITS'($urandom), CODE_BITS'($urandom),
              LEN_BITS'($urandom), SYM_BITS'($urandom), bit_in);
  endtask

  // drop valid and wait until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // empty the slots in use, then load a random complete prefix code
  task automatic load_code(input bit deep);
    int old_slots [$];
    bit used [NUM_SLOTS];
    int n_sym;
    int k;
    int c;
    int l;
    int idx;
    old_slots = live_slots;
    live_slots.delete();
    foreach (old_slots[i]) begin
      send_load(old_slots[i], $urandom_range(0, 65535),
                $urandom_range(0, 1) ? 0 : $urandom_range(17, 31), $urandom_range(0, 255));
    end
    live_slots.delete();
    // grow a code tree by splitting leaves; deep trees keep splitting the newest leaf
    n_sym = deep ? $urandom_range(10, 24) : $urandom_range(2, 12);
    word_code = '{0, 1};
    word_len  = '{1, 1};
    while (word_code.size() < n_sym) begin
      k = (deep && $urandom_range(0, 1)) ? word_code.size() - 1
                                         : $urandom_range(0, word_code.size() - 1);
      if (word_len[k] < MAX_LEN) begin
        c = word_code[k];
        l = word_len[k];
        word_code.delete(k);
        word_len.delete(k);
        word_code.insert(word_code.size(), c * 2);
        word_len.insert(word_len.size(), l + 1);
        word_code.insert(word_code.size(), c * 2 + 1);
        word_len.insert(word_len.size(), l + 1);
      end
    end
    foreach (word_code[i]) begin
      do idx = $urandom_range(0, NUM_SLOTS - 1); while (used[idx]);
      used[idx] = 1'b1;
      send_load(idx, word_code[i], word_len[i], $urandom_range(0, 255));
    end
    // sometimes a second slot with the same code and another symbol
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, word_code.size() - 1);
      do idx = $urandom_range(0, NUM_SLOTS - 1); while (used[idx]);
      send_load(idx, word_code[k], word_len[k], $urandom_range(0, 255));
    end
  endtask

  // one random phase: fresh code, then code words with some noise
  task automatic run_phase(input int phase_no);
    int n_words;
    int k;
    send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
    recv_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
    if (phase_no == 4) drain_results();
    load_code($urandom_range(0, 2) == 0);
    if (phase_no == 2) hold_req = 1'b1;
    n_words = $urandom_range(15, 40);
    for (int w = 0; w < n_words; w++) begin
      // stop close to the planned number of transactions
      if (n_sent >= ITEM_TARGET) break;
      k = $urandom_range(0, 99);
      if (k < 8) begin
        send_bit(1'($urandom_range(0, 1)));
      end else if (k < 11) begin
        send_load($urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, 65535),
                  $urandom_range(0, 31), $urandom_range(0, 255));
      end else begin
        k = $urandom_range(0, word_code.size() - 1);
        for (int b = word_len[k] - 1; b >= 0; b--) send_bit(1'((word_code[k] >> b) & 1));
      end
    end
  endtask

  // main sequence
  initial begin
    int phase_no;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed corners: extreme slot and code, lengths above sixteen,
    // duplicate codes with the lowest index winning, a match on the last
    // allowed bit, and a zero length emptying a slot
    send_load(255, 16'hFFFF, 16, 8'hFF);
    send_load(10, 1, 17, 8'h11);
    send_load(20, 1, 31, 8'h22);
    send_load(5, 1, 2, 8'h33);
    send_load(3, 1, 2, 8'h44);
    send_bit(1'b0);
    send_bit(1'b1);
    repeat (MAX_LEN) send_bit(1'b1);
    send_load(0, 0, 0, 8'h00);
    send_load(3, 1, 0, 8'h44);
    send_bit(1'b0);
    send_bit(1'b1);

    // random phases, the last stretch without idling
    phase_no = 0;
    while (n_sent < ITEM_TARGET - QUIET_ITEMS) begin
      phase_no++;
      run_phase(phase_no);
    end
    quiet = 1'b1;
    while (n_sent < ITEM_TARGET) begin
      phase_no++;
      run_phase(phase_no);
    end

    // wait out outstanding results and any trailing activity
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d phases, %0d load and %0d bit transactions, %0d long hold-offs",
             phase_no, sb.n_loads, sb.n_bits, n_holds);
    $display("summary: %0d symbols decoded, %0d overflows, %0d mismatches",
             sb.n_decoded, sb.n_overflow, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
